// ===== src/bipx_pkg.sv =====
// Shared types, constants and helpers for the bound-ip register machine.
package bipx_pkg;

  localparam int NUM_REGS    = 6;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int PROG_DEPTH  = 4096;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OPND_W      = 24;
  localparam int DATA_W      = 64;
  localparam int CFG_DATA_W  = 13;

  localparam logic [11:0] WATCH_ADDR_RST = 12'd28;
  localparam logic [2:0]  WATCH_REG_RST  = 3'd1;

  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,  OP_ADDI = 4'd1,  OP_MULR = 4'd2,  OP_MULI = 4'd3,
    OP_BANR = 4'd4,  OP_BANI = 4'd5,  OP_BORR = 4'd6,  OP_BORI = 4'd7,
    OP_SETR = 4'd8,  OP_SETI = 4'd9,  OP_GTIR = 4'd10, OP_GTRI = 4'd11,
    OP_GTRR = 4'd12, OP_EQIR = 4'd13, OP_EQRI = 4'd14, OP_EQRR = 4'd15
  } opcode_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_MUL, ALU_AND, ALU_OR, ALU_SET, ALU_GT, ALU_EQ
  } alu_t;

  typedef enum logic [1:0] {
    CFG_IP_BINDING, CFG_PROG_LEN, CFG_WATCH_ADDR, CFG_WATCH_REG
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EX_RUN, EX_MUL_LH, EX_MUL_HL, EX_MUL_WB
  } ex_state_t;

  // Decoded instruction as it sits in the queue.
  typedef struct packed {
    alu_t              alu;
    logic              a_reg;
    logic              b_reg;
    logic [OPND_W-1:0] operand_a;
    logic [OPND_W-1:0] operand_b;
    logic [2:0]        dest;
    logic              err;
  } uop_t;

  // Raw outcome of one executed instruction, before address checks.
  typedef struct packed {
    logic              err;
    logic              ip_bad;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] watched;
  } res_t;

  function automatic logic reg_ok(logic [OPND_W-1:0] idx);
    reg_ok = (32'(idx) < NUM_REGS);
  endfunction

endpackage

// ===== src/bound_ip_register_machine_exec_core.sv =====
// Top level: configuration registers, front end, queue, execute and output register.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | opcode, operand_a, operand_b, dest_index
//  out     | out_valid / out_ready| next_ip, halted, watch_hit, watched_value,
//          |                      | index_error
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One instruction per cycle for every opcode but multiply, while the output
// register is not stalled; a multiply holds the execute unit while the shared
// 32x32 multiplier forms three partial products, then writes the result.
// The two-entry queue lets the input keep taking words while execute or the
// output stalls. Reset clears all six registers and restores the config
// defaults.
module bound_ip_register_machine_exec_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [3:0]                          in_opcode,
  input  logic [bipx_pkg::OPND_W-1:0]         in_operand_a,
  input  logic [bipx_pkg::OPND_W-1:0]         in_operand_b,
  input  logic [2:0]                          in_dest_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [11:0]                         out_next_ip,
  output logic                                out_halted,
  output logic                                out_watch_hit,
  output logic signed [bipx_pkg::DATA_W-1:0]  out_watched_value,
  output logic                                out_index_error,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [bipx_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int W = bipx_pkg::DATA_W;

  logic [2:0]           ip_binding_r;
  logic [12:0]          program_length_r;
  logic [11:0]          watch_address_r;
  logic [2:0]           watch_register_r;

  logic                 q_full, q_push, q_pop, q_head_valid;
  bipx_pkg::uop_t       q_wdata, q_head;
  logic                 res_valid, res_ready;
  bipx_pkg::res_t       res;

  logic                 out_valid_r;
  logic [11:0]          next_ip_r;
  logic                 halted_r, watch_hit_r, index_error_r;
  logic [W-1:0]         watched_r;

  logic [W-1:0]         limit;
  logic                 halted, watch_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_binding_r     <= '0;
      program_length_r <= '0;
      watch_address_r  <= bipx_pkg::WATCH_ADDR_RST;
      watch_register_r <= bipx_pkg::WATCH_REG_RST;
    end else if (cfg_we) begin
      unique case (bipx_pkg::cfg_idx_t'(cfg_index))
        bipx_pkg::CFG_IP_BINDING: ip_binding_r     <= cfg_data[2:0];
        bipx_pkg::CFG_PROG_LEN:   program_length_r <= cfg_data[12:0];
        bipx_pkg::CFG_WATCH_ADDR: watch_address_r  <= cfg_data[11:0];
        bipx_pkg::CFG_WATCH_REG:  watch_register_r <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  bipx_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .in_dest_index (in_dest_index),
    .ip_binding    (ip_binding_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  bipx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wdata      (q_wdata),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  bipx_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head           (q_head),
    .pop            (q_pop),
    .ip_binding     (ip_binding_r),
    .watch_register (watch_register_r),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  // clamp the program length to the program store depth
  assign limit = (W'(program_length_r) > W'(bipx_pkg::PROG_DEPTH)) ?
                 W'(bipx_pkg::PROG_DEPTH) : W'(program_length_r);

  assign halted    = res.ip_bad || res.addr[W-1] || (res.addr >= limit);
  assign watch_hit = !res.ip_bad && (res.addr == W'(watch_address_r));
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      next_ip_r     <= halted ? '0 : res.addr[11:0];
      halted_r      <= halted;
      watch_hit_r   <= watch_hit;
      watched_r     <= res.watched;
      index_error_r <= res.err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_ip       = next_ip_r;
  assign out_halted        = halted_r;
  assign out_watch_hit     = watch_hit_r;
  assign out_watched_value = $signed(watched_r);
  assign out_index_error   = index_error_r;

endmodule

// ===== src/bipx_front.sv =====
// Front end: decodes each instruction word and checks its register indexes.
module bipx_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [3:0]                in_opcode,
  input  logic [bipx_pkg::OPND_W-1:0] in_operand_a,
  input  logic [bipx_pkg::OPND_W-1:0] in_operand_b,
  input  logic [2:0]                in_dest_index,
  input  logic [2:0]                ip_binding,
  input  logic                      q_full,
  output logic                      q_push,
  output bipx_pkg::uop_t            q_wdata
);

  bipx_pkg::alu_t alu;
  logic           a_reg;
  logic           b_reg;

  always_comb begin
    unique case (bipx_pkg::opcode_t'(in_opcode))
      bipx_pkg::OP_ADDR: begin alu = bipx_pkg::ALU_ADD; a_reg = 1'b1; b_reg = 1'b1; end
      bipx_pkg::OP_ADDI: begin alu = bipx_pkg::ALU_ADD; a_reg = 1'b1; b_reg = 1'b0; end
      bipx_pkg::OP_MULR: begin alu = bipx_pkg::ALU_MUL; a_reg = 1'b1; b_reg = 1'b1; end
      bipx_pkg::OP_MULI: begin alu = bipx_pkg::ALU_MUL; a_reg = 1'b1; b_reg = 1'b0; end
      bipx_pkg::OP_BANR: begin alu = bipx_pkg::ALU_AND; a_reg = 1'b1; b_reg = 1'b1; end
      bipx_pkg::OP_BANI: begin alu = bipx_pkg::ALU_AND; a_reg = 1'b1; b_reg = 1'b0; end
      bipx_pkg::OP_BORR: begin alu = bipx_pkg::ALU_OR;  a_reg = 1'b1; b_reg = 1'b1; end
      bipx_pkg::OP_BORI: begin alu = bipx_pkg::ALU_OR;  a_reg = 1'b1; b_reg = 1'b0; end
      bipx_pkg::OP_SETR: begin alu = bipx_pkg::ALU_SET; a_reg = 1'b1; b_reg = 1'b0; end
      bipx_pkg::OP_SETI: begin alu = bipx_pkg::ALU_SET; a_reg = 1'b0; b_reg = 1'b0; end
      bipx_pkg::OP_GTIR: begin alu = bipx_pkg::ALU_GT;  a_reg = 1'b0; b_reg = 1'b1; end
      bipx_pkg::OP_GTRI: begin alu = bipx_pkg::ALU_GT;  a_reg = 1'b1; b_reg = 1'b0; end
      bipx_pkg::OP_GTRR: begin alu = bipx_pkg::ALU_GT;  a_reg = 1'b1; b_reg = 1'b1; end
      bipx_pkg::OP_EQIR: begin alu = bipx_pkg::ALU_EQ;  a_reg = 1'b0; b_reg = 1'b1; end
      bipx_pkg::OP_EQRI: begin alu = bipx_pkg::ALU_EQ;  a_reg = 1'b1; b_reg = 1'b0; end
      bipx_pkg::OP_EQRR: begin alu = bipx_pkg::ALU_EQ;  a_reg = 1'b1; b_reg = 1'b1; end
      default:           begin alu = bipx_pkg::ALU_EQ;  a_reg = 1'b1; b_reg = 1'b1; end
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.alu       = alu;
    q_wdata.a_reg     = a_reg;
    q_wdata.b_reg     = b_reg;
    q_wdata.operand_a = in_operand_a;
    q_wdata.operand_b = in_operand_b;
    q_wdata.dest      = in_dest_index;
    // any bad index, including the ip binding, turns the step into a no-op
    q_wdata.err = !bipx_pkg::reg_ok(bipx_pkg::OPND_W'(ip_binding)) ||
                  !bipx_pkg::reg_ok(bipx_pkg::OPND_W'(in_dest_index)) ||
                  (a_reg && !bipx_pkg::reg_ok(in_operand_a)) ||
                  (b_reg && !bipx_pkg::reg_ok(in_operand_b));
  end

endmodule

// ===== src/bipx_queue.sv =====
// Small FIFO of decoded instructions between front end and execute.
module bipx_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bipx_pkg::uop_t wdata,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output bipx_pkg::uop_t head
);

  bipx_pkg::uop_t                   mem_r [bipx_pkg::QUEUE_DEPTH];
  logic [bipx_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [bipx_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [bipx_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  assign full       = (cnt_r == bipx_pkg::QCNT_W'(bipx_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  function automatic logic [bipx_pkg::QPTR_W-1:0] ptr_inc(logic [bipx_pkg::QPTR_W-1:0] p);
    if (32'(p) == bipx_pkg::QUEUE_DEPTH - 1) ptr_inc = '0;
    else ptr_inc = p + bipx_pkg::QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + bipx_pkg::QCNT_W'(push) - bipx_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/bipx_back.sv =====
// Execute: register file, ALU, shared 32x32 multiplier and result register.
module bipx_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  bipx_pkg::uop_t head,
  output logic           pop,
  input  logic [2:0]     ip_binding,
  input  logic [2:0]     watch_register,
  output logic           res_valid,
  output bipx_pkg::res_t res,
  input  logic           res_ready
);

  localparam int W  = bipx_pkg::DATA_W;
  localparam int HW = W / 2;
  localparam int IW = bipx_pkg::REG_IDX_W;

  logic [W-1:0]         rf_r   [bipx_pkg::NUM_REGS];
  logic [W-1:0]         rf_nxt [bipx_pkg::NUM_REGS];

  bipx_pkg::ex_state_t  state_r, state_nxt;
  logic [W-1:0]         acc_r;
  logic [W-1:0]         ra_r, rb_r;
  logic                 res_valid_r;
  bipx_pkg::res_t       res_r;

  logic [W-1:0]         ra, rb, alu_res, wr_val;
  logic [HW-1:0]        mul_x, mul_y;
  logic [W-1:0]         prod;
  logic                 res_load, emit, rf_we, mul_start;
  logic [IW-1:0]        a_idx, b_idx, dest_idx, ip_idx, watch_idx;
  logic                 ip_ok, watch_ok;

  assign a_idx     = head.operand_a[IW-1:0];
  assign b_idx     = head.operand_b[IW-1:0];
  assign dest_idx  = IW'(head.dest);
  assign ip_idx    = IW'(ip_binding);
  assign watch_idx = IW'(watch_register);
  assign ip_ok     = bipx_pkg::reg_ok(bipx_pkg::OPND_W'(ip_binding));
  assign watch_ok  = bipx_pkg::reg_ok(bipx_pkg::OPND_W'(watch_register));

  assign ra = head.a_reg ? rf_r[a_idx] : W'(head.operand_a);
  assign rb = head.b_reg ? rf_r[b_idx] : W'(head.operand_b);

  always_comb begin
    unique case (head.alu)
      bipx_pkg::ALU_ADD: alu_res = ra + rb;
      bipx_pkg::ALU_AND: alu_res = ra & rb;
      bipx_pkg::ALU_OR:  alu_res = ra | rb;
      bipx_pkg::ALU_SET: alu_res = ra;
      bipx_pkg::ALU_GT:  alu_res = W'($signed(ra) > $signed(rb));
      bipx_pkg::ALU_EQ:  alu_res = W'(ra == rb);
      default:           alu_res = acc_r;
    endcase
  end

  // One 32x32 multiplier: low x low, then the two cross terms into the upper half
  always_comb begin
    unique case (state_r)
      bipx_pkg::EX_MUL_LH: begin mul_x = ra_r[HW-1:0]; mul_y = rb_r[W-1:HW]; end
      bipx_pkg::EX_MUL_HL: begin mul_x = ra_r[W-1:HW]; mul_y = rb_r[HW-1:0]; end
      default:             begin mul_x = ra[HW-1:0];   mul_y = rb[HW-1:0];   end
    endcase
  end

  assign prod     = mul_x * mul_y;
  assign res_load = !res_valid_r || res_ready;
  assign wr_val   = (state_r == bipx_pkg::EX_MUL_WB) ? acc_r : alu_res;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bipx_pkg::EX_RUN:    if (mul_start) state_nxt = bipx_pkg::EX_MUL_LH;
      bipx_pkg::EX_MUL_LH: state_nxt = bipx_pkg::EX_MUL_HL;
      bipx_pkg::EX_MUL_HL: state_nxt = bipx_pkg::EX_MUL_WB;
      bipx_pkg::EX_MUL_WB: if (res_load) state_nxt = bipx_pkg::EX_RUN;
      default:             state_nxt = bipx_pkg::EX_RUN;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    rf_we     = 1'b0;
    mul_start = 1'b0;
    unique case (state_r)
      bipx_pkg::EX_RUN: begin
        mul_start = head_valid && !head.err && (head.alu == bipx_pkg::ALU_MUL);
        if (head_valid && res_load && (head.err || head.alu != bipx_pkg::ALU_MUL)) begin
          pop   = 1'b1;
          emit  = 1'b1;
          rf_we = !head.err;
        end
      end
      bipx_pkg::EX_MUL_WB: begin
        if (res_load) begin
          pop   = 1'b1;
          emit  = 1'b1;
          rf_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // destination write, then bump the bound register
  always_comb begin
    for (int i = 0; i < bipx_pkg::NUM_REGS; i++) begin
      rf_nxt[i] = rf_r[i];
      if (rf_we) begin
        if (IW'(i) == dest_idx) rf_nxt[i] = wr_val;
        if (IW'(i) == ip_idx)   rf_nxt[i] = rf_nxt[i] + W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bipx_pkg::EX_RUN;
      res_valid_r <= 1'b0;
      for (int i = 0; i < bipx_pkg::NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (emit) res_valid_r <= 1'b1;
      else if (res_ready) res_valid_r <= 1'b0;
      for (int i = 0; i < bipx_pkg::NUM_REGS; i++) begin
        rf_r[i] <= rf_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      ra_r  <= ra;
      rb_r  <= rb;
      acc_r <= prod;
    end else if (state_r == bipx_pkg::EX_MUL_LH || state_r == bipx_pkg::EX_MUL_HL) begin
      acc_r[W-1:HW] <= acc_r[W-1:HW] + prod[HW-1:0];
    end
    if (emit) begin
      res_r.err     <= head.err;
      res_r.ip_bad  <= !ip_ok;
      res_r.addr    <= rf_nxt[ip_idx];
      res_r.watched <= watch_ok ? rf_nxt[watch_idx] : '0;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== test/bipx_exec_checker.sv =====
// Checker for the bound-ip register machine: shadow register file, expected results and compare.
module bipx_exec_checker
  import bipx_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [3:0]               in_opcode,
  input  logic [OPND_W-1:0]        in_operand_a,
  input  logic [OPND_W-1:0]        in_operand_b,
  input  logic [2:0]               in_dest_index,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [11:0]              out_next_ip,
  input  logic                     out_halted,
  input  logic                     out_watch_hit,
  input  logic signed [DATA_W-1:0] out_watched_value,
  input  logic                     out_index_error,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       fail_count,
  output int                       words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0]       next_ip;
    logic              halted;
    logic              watch_hit;
    logic [DATA_W-1:0] watched_value;
    logic              index_error;
  } step_report_t;

  logic [DATA_W-1:0] shadow_regs [NUM_REGS];
  logic [2:0]        ip_sel;
  logic [12:0]       prog_len;
  logic [11:0]       watch_addr;
  logic [2:0]        watch_sel;
  step_report_t      report_q [$];

  // Execute one instruction on the shadow file and report what the block should return.
  function automatic step_report_t execute_instr(input opcode_t op,
                                                 input logic [OPND_W-1:0] a,
                                                 input logic [OPND_W-1:0] b,
                                                 input logic [2:0] dest);
    logic              a_is_reg;
    logic              b_is_reg;
    logic              bad;
    logic [DATA_W-1:0] va;
    logic [DATA_W-1:0] vb;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] addr;
    logic [12:0]       limit;
    step_report_t      rep;
    case (op)
      OP_SETI, OP_GTIR, OP_EQIR: a_is_reg = 1'b0;
      default: a_is_reg = 1'b1;
    endcase
    case (op)
      OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: b_is_reg = 1'b1;
      default: b_is_reg = 1'b0;
    endcase
    bad = (ip_sel >= NUM_REGS) || (dest >= NUM_REGS) ||
          (a_is_reg && a >= NUM_REGS) || (b_is_reg && b >= NUM_REGS);
    if (!bad) begin
      if (a_is_reg) va = shadow_regs[a];
      else          va = DATA_W'(a);
      if (b_is_reg) vb = shadow_regs[b];
      else          vb = DATA_W'(b);
      case (op)
        OP_ADDR, OP_ADDI: res = va + vb;
        OP_MULR, OP_MULI: res = va * vb;
        OP_BANR, OP_BANI: res = va & vb;
        OP_BORR, OP_BORI: res = va | vb;
        OP_SETR, OP_SETI: res = va;
        OP_GTIR, OP_GTRI, OP_GTRR: res = DATA_W'($signed(va) > $signed(vb));
        default: res = DATA_W'(va == vb);
      endcase
      shadow_regs[dest] = res;
      shadow_regs[ip_sel] = shadow_regs[ip_sel] + 1;
    end
    // program lengths past the store depth clamp to it
    limit = (prog_len > PROG_DEPTH) ? 13'(PROG_DEPTH) : prog_len;
    if (ip_sel < NUM_REGS) begin
      addr          = shadow_regs[ip_sel];
      rep.halted    = addr[DATA_W-1] || (addr >= DATA_W'(limit));
      rep.watch_hit = (addr == DATA_W'(watch_addr));
      rep.next_ip   = rep.halted ? 12'd0 : addr[11:0];
    end else begin
      rep.halted    = 1'b1;
      rep.watch_hit = 1'b0;
      rep.next_ip   = 12'd0;
    end
    rep.watched_value = (watch_sel < NUM_REGS) ? shadow_regs[watch_sel] : '0;
    rep.index_error   = bad;
    return rep;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    step_report_t want;
    if (!rst_n) begin
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      ip_sel     = 3'd0;
      prog_len   = 13'd0;
      watch_addr = WATCH_ADDR_RST;
      watch_sel  = WATCH_REG_RST;
      report_q.delete();
      fail_count = 0;
      words_due <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_IP_BINDING: ip_sel     = cfg_data[2:0];
          CFG_PROG_LEN:   prog_len   = cfg_data[12:0];
          CFG_WATCH_ADDR: watch_addr = cfg_data[11:0];
          default:        watch_sel  = cfg_data[2:0];
        endcase
      end
      // match the outgoing word before queueing a new one
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $error("result word with no instruction outstanding");
          fail_count++;
        end else begin
          want = report_q.pop_front();
          check_field("next_ip", DATA_W'(want.next_ip), DATA_W'(out_next_ip));
          check_field("halted", DATA_W'(want.halted), DATA_W'(out_halted));
          check_field("watch_hit", DATA_W'(want.watch_hit), DATA_W'(out_watch_hit));
          check_field("watched_value", want.watched_value, out_watched_value);
          check_field("index_error", DATA_W'(want.index_error), DATA_W'(out_index_error));
        end
      end
      if (in_valid && in_ready)
        report_q = {report_q, execute_instr(opcode_t'(in_opcode), in_operand_a,
                                            in_operand_b, in_dest_index)};
      words_due <= report_q.size();
    end
  end

endmodule

// ===== test/tb_bound_ip_register_machine_exec_core.sv =====
// Testbench top for the bound-ip register machine: stimulus, output stalls and verdict.
module tb_bound_ip_register_machine_exec_core;
  import bipx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 12;

  logic                     clk;
  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic [3:0]               in_opcode     = '0;
  logic [OPND_W-1:0]        in_operand_a  = '0;
  logic [OPND_W-1:0]        in_operand_b  = '0;
  logic [2:0]               in_dest_index = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic [11:0]              out_next_ip;
  logic                     out_halted;
  logic                     out_watch_hit;
  logic signed [DATA_W-1:0] out_watched_value;
  logic                     out_index_error;
  logic                     cfg_we        = 1'b0;
  logic [1:0]               cfg_index     = '0;
  logic [CFG_DATA_W-1:0]    cfg_data      = '0;
  int                       fail_count;
  int                       words_due;

  int          cycles     = 0;
  int          words_in   = 0;
  int          burst_left = 0;
  int          n_settings = 0;
  logic [2:0]  cur_ip;
  logic [12:0] cur_len;
  logic [11:0] cur_watch;

  bound_ip_register_machine_exec_core i_dut (.*);

  bipx_exec_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && in_ready) words_in <= words_in + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, words_due);
      $display("status: fail");
      $finish;
    end
  end

  // Output side: stretches of steady, patchy and mostly stalled ready, plus one long hold.
  initial begin
    int  mode;
    int  stretch;
    bit  held_long;
    held_long = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_long && words_in >= 300) begin
        out_ready <= 1'b0;
        repeat (120) @(posedge clk);
        held_long = 1'b1;
      end
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(4, 40);
      repeat (stretch) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one instruction word; bursts end in random gaps.
  task automatic issue(input opcode_t op, input logic [OPND_W-1:0] a,
                       input logic [OPND_W-1:0] b, input logic [2:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_operand_a  <= a;
    in_operand_b  <= b;
    in_dest_index <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the input until every outstanding result is back, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] ip, input logic [12:0] len,
                            input logic [11:0] wa, input logic [2:0] wr);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IP_BINDING;
    cfg_data  <= CFG_DATA_W'(ip);
    @(posedge clk);
    cfg_index <= CFG_PROG_LEN;
    cfg_data  <= len;
    @(posedge clk);
    cfg_index <= CFG_WATCH_ADDR;
    cfg_data  <= CFG_DATA_W'(wa);
    @(posedge clk);
    cfg_index <= CFG_WATCH_REG;
    cfg_data  <= CFG_DATA_W'(wr);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_ip    = ip;
    cur_len   = len;
    cur_watch = wa;
    n_settings++;
  endtask

  function automatic logic [OPND_W-1:0] pick_imm();
    case ($urandom_range(0, 9))
      0, 1, 2: return OPND_W'($urandom_range(0, 15));
      3, 4:    return 24'hFFFFFF - OPND_W'($urandom_range(0, 15));
      default: return OPND_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed instructions, some jumps of the bound register, a few bad indices.
  task automatic random_instr();
    opcode_t           op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic [2:0]        d;
    int                pick;
    int                span;
    int                target;
    pick = $urandom_range(0, 99);
    op   = opcode_t'($urandom_range(0, 15));
    d    = 3'($urandom_range(0, NUM_REGS - 1));
    case (op)
      OP_SETI, OP_GTIR, OP_EQIR: a = pick_imm();
      default: a = OPND_W'($urandom_range(0, NUM_REGS - 1));
    endcase
    case (op)
      OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR:
        b = OPND_W'($urandom_range(0, NUM_REGS - 1));
      default: b = pick_imm();
    endcase
    if (pick < 6) begin
      case ($urandom_range(0, 2))
        0: d = 3'($urandom_range(NUM_REGS, 7));
        1: a = OPND_W'($urandom_range(NUM_REGS, 24'hFFFFFF));
        default: b = OPND_W'($urandom_range(NUM_REGS, 24'hFFFFFF));
      endcase
    end else if (pick < 18) begin
      // steer the bound register back into the program, often onto the watch address
      span = ((cur_len > PROG_DEPTH) ? PROG_DEPTH : int'(cur_len)) + 1;
      case ($urandom_range(0, 2))
        0: target = (cur_watch == 0) ? 0 : int'(cur_watch) - 1;
        1: target = $urandom_range(0, span);
        default: target = $urandom_range(0, 40);
      endcase
      d = cur_ip;
      if (pick < 14) begin
        op = OP_SETI;
        a  = OPND_W'(target);
      end else begin
        op = OP_ADDI;
        a  = OPND_W'(cur_ip);
        b  = OPND_W'($urandom_range(0, 3));
      end
    end
    issue(op, a, b, d);
  endtask

  initial begin
    int n_items;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bound register r5, long program clamps to the store depth
    set_config(3'd5, 13'd8191, 12'd10, 3'd3);
    issue(OP_SETI, 24'hFFFFFF, 24'hFFFFFF, 3'd0);
    issue(OP_ADDI, 24'd0, 24'hFFFFFF, 3'd1);
    issue(OP_ADDR, 24'd0, 24'd1, 3'd2);
    issue(OP_MULR, 24'd0, 24'd0, 3'd3);
    issue(OP_MULI, 24'd3, 24'hFFFFFF, 3'd3);
    issue(OP_BANR, 24'd3, 24'd0, 3'd4);
    issue(OP_BANI, 24'd3, 24'hABCDEF, 3'd4);
    issue(OP_BORR, 24'd0, 24'd1, 3'd2);
    issue(OP_BORI, 24'd2, 24'h800000, 3'd2);
    issue(OP_SETR, 24'd4, 24'd0, 3'd1);
    issue(OP_GTIR, 24'hFFFFFF, 24'd0, 3'd2);
    issue(OP_GTRI, 24'd0, 24'd5, 3'd2);
    issue(OP_GTRR, 24'd3, 24'd0, 3'd1);
    issue(OP_EQIR, 24'd5, 24'd5, 3'd2);
    issue(OP_EQRI, 24'd0, 24'hFFFFFF, 3'd1);
    issue(OP_EQRR, 24'd0, 24'd0, 3'd2);
    issue(OP_ADDI, 24'd0, 24'd1, 3'd7);
    issue(OP_ADDR, 24'd6, 24'd0, 3'd0);
    issue(OP_MULR, 24'd1, 24'hFFFFFF, 3'd0);
    // build 2^63 in r3 and load it into the bound register: negative address
    issue(OP_SETI, 24'h800000, 24'd0, 3'd3);
    issue(OP_MULR, 24'd3, 24'd3, 3'd3);
    issue(OP_MULI, 24'd3, 24'h020000, 3'd3);
    issue(OP_SETR, 24'd3, 24'd0, 3'd5);
    issue(OP_SETI, 24'd9, 24'd0, 3'd5);
    issue(OP_SETI, 24'd4095, 24'd0, 3'd5);
    issue(OP_SETI, 24'd4094, 24'd0, 3'd5);

    // out-of-range ip binding and watch register
    set_config(3'd7, 13'd0, 12'd0, 3'd6);
    issue(OP_ADDI, 24'd0, 24'd1, 3'd0);
    issue(OP_MULR, 24'd1, 24'd2, 3'd3);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(3'd0, 13'd4096, 12'($urandom_range(0, 40)),
                      3'($urandom_range(0, NUM_REGS - 1)));
        1: set_config(3'd5, 13'd0, 12'd0, 3'd5);
        2: set_config(3'd3, 13'($urandom_range(1, 300)), 12'd4095, 3'd7);
        3: set_config(3'd1, 13'd8191, 12'($urandom_range(0, 40)), 3'd0);
        4: set_config(3'($urandom_range(0, NUM_REGS - 1)), 13'($urandom_range(0, 8191)),
                      12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)));
        default: set_config(3'd6, 13'($urandom_range(0, 8191)), 12'($urandom_range(0, 4095)),
                            3'($urandom_range(0, NUM_REGS - 1)));
      endcase
      n_items = (ph == 5) ? 15 : 145;
      repeat (n_items) random_instr();
    end

    drain_results();
    $display("%0d instructions over %0d register settings: all opcodes, bad indices,",
             words_in, n_settings);
    $display("bad ip and watch selects, negative and clamped addresses, watch hits, long stall");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
